### sv/sexpr_input_completeness_unit_macros.svh
// assertion macros for the s-expression completeness unit
// defining NO_ASSERTIONS compiles every check away
`ifndef SEXPR_INPUT_COMPLETENESS_UNIT_MACROS_SVH
`define SEXPR_INPUT_COMPLETENESS_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle property, checked outside reset
`define SIC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent now, consequent in the cycle after
`define SIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SIC_ASSERT(label, clk, rst, prop, msg)
`define SIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### sv/sic_pkg.sv
// shared types and constants for the s-expression completeness unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sic_pkg;

   // depth limits for parens and block comments
   localparam int DEPTH_MAX = 255;
   localparam int DEPTH_W   = $clog2(DEPTH_MAX + 1);

   // indent hint
   localparam int INDENT_W   = 9;
   localparam int INDENT_MAX = 510;

   // characters of interest
   localparam logic [7:0] CHAR_HASH   = 8'h23;
   localparam logic [7:0] CHAR_BAR    = 8'h7c;
   localparam logic [7:0] CHAR_SEMI   = 8'h3b;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_DOT    = 8'h2e;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0d;
   localparam logic [7:0] CHAR_NL     = 8'h0a;
   localparam logic [7:0] CHAR_OPEN   = 8'h28;
   localparam logic [7:0] CHAR_CLOSE  = 8'h29;

   // one input word
   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
   } sic_item_type;

   // scanner state
   typedef struct packed {
      logic [DEPTH_W-1:0] open_parens;
      logic [DEPTH_W-1:0] comment_nesting;
      logic               inside_string;
      logic               escape_pending;
      logic               inside_line_comment;
      logic               hash_pending;
      logic               bar_pending;
      logic               line_blank_so_far;
      logic               dot_continuation;
   } sic_state_type;

   localparam sic_state_type STATE_RESET = '{
      open_parens:         '0,
      comment_nesting:     '0,
      inside_string:       1'b0,
      escape_pending:      1'b0,
      inside_line_comment: 1'b0,
      hash_pending:        1'b0,
      bar_pending:         1'b0,
      line_blank_so_far:   1'b1,
      dot_continuation:    1'b0
   };

   // one result word
   typedef struct packed {
      logic                complete;
      logic [INDENT_W-1:0] indent_width;
   } sic_result_type;

endpackage

`default_nettype wire

### sv/sic_input_reg.sv
// input register stage: holds one word until the scanner consumes it
// depends on sic_pkg
`timescale 1ns / 1ps
`default_nettype none

module sic_input_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire sic_pkg::sic_item_type req_item,
   input  wire logic                  hold,
   output logic                       item_valid,
   output sic_pkg::sic_item_type      item,
   output logic                       step
);

   logic                  valid_ff;
   logic                  valid_in;
   sic_pkg::sic_item_type item_ff;
   logic                  load;

   // consume when valid and the result side is not blocking
   assign step      = valid_ff && !hold;
   assign req_ready = !valid_ff || step;
   assign load      = req_valid && req_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (step) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### sv/sic_scanner.sv
// per-byte scanner: paren, string, comment and dot-line tracking
// depends on sic_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "sexpr_input_completeness_unit_macros.svh"

module sic_scanner (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire sic_pkg::sic_item_type item,
   output sic_pkg::sic_result_type    result
);

   sic_pkg::sic_state_type state_ff;
   sic_pkg::sic_state_type state_in;
   sic_pkg::sic_state_type nxt;
   logic [7:0]             c;
   logic                   is_blank;
   logic                   taken;
   logic                   done;

   function automatic logic [sic_pkg::DEPTH_W-1:0] sat_inc(
      input logic [sic_pkg::DEPTH_W-1:0] v
   );
      logic [sic_pkg::DEPTH_W-1:0] r;
      r = v;
      if (v < sic_pkg::DEPTH_W'(sic_pkg::DEPTH_MAX)) begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   assign c        = item.text_byte;
   assign is_blank = (c == sic_pkg::CHAR_SPACE) || (c == sic_pkg::CHAR_TAB) ||
                     (c == sic_pkg::CHAR_CR);

   // next state for one byte
   always_comb begin
      nxt   = state_ff;
      taken = 1'b0;

      // line scan on raw bytes
      if (c == sic_pkg::CHAR_NL) begin
         nxt.line_blank_so_far = 1'b1;
      end else if (state_ff.line_blank_so_far && !is_blank) begin
         nxt.line_blank_so_far = 1'b0;
         if (c != sic_pkg::CHAR_SEMI) begin
            nxt.dot_continuation = (c == sic_pkg::CHAR_DOT);
         end
      end

      if (state_ff.inside_line_comment) begin
         // line comment ends at newline
         if (c == sic_pkg::CHAR_NL) begin
            nxt.inside_line_comment = 1'b0;
         end
      end else if (state_ff.comment_nesting != '0) begin
         // block comment: look for nested open or close marks
         if (state_ff.hash_pending) begin
            nxt.hash_pending = 1'b0;
            if (c == sic_pkg::CHAR_BAR) begin
               nxt.comment_nesting = sat_inc(state_ff.comment_nesting);
               taken               = 1'b1;
            end
         end else if (state_ff.bar_pending) begin
            nxt.bar_pending = 1'b0;
            if (c == sic_pkg::CHAR_HASH) begin
               nxt.comment_nesting = state_ff.comment_nesting - 1'b1;
               taken               = 1'b1;
            end
         end
         if (!taken) begin
            if (c == sic_pkg::CHAR_HASH) begin
               nxt.hash_pending = 1'b1;
            end else if (c == sic_pkg::CHAR_BAR) begin
               nxt.bar_pending = 1'b1;
            end
         end
      end else if (state_ff.inside_string) begin
         // string with backslash escapes
         if (state_ff.escape_pending) begin
            nxt.escape_pending = 1'b0;
         end else if (c == sic_pkg::CHAR_BSLASH) begin
            nxt.escape_pending = 1'b1;
         end else if (c == sic_pkg::CHAR_QUOTE) begin
            nxt.inside_string = 1'b0;
         end
      end else begin
         // plain code
         if (state_ff.hash_pending) begin
            nxt.hash_pending = 1'b0;
            if (c == sic_pkg::CHAR_BAR) begin
               nxt.comment_nesting = sat_inc(state_ff.comment_nesting);
               taken               = 1'b1;
            end
         end
         if (!taken) begin
            if (c == sic_pkg::CHAR_SEMI) begin
               nxt.inside_line_comment = 1'b1;
            end else if (c == sic_pkg::CHAR_HASH) begin
               nxt.hash_pending = 1'b1;
            end else if (c == sic_pkg::CHAR_QUOTE) begin
               nxt.inside_string = 1'b1;
            end else if (c == sic_pkg::CHAR_OPEN) begin
               nxt.open_parens = sat_inc(state_ff.open_parens);
            end else if (c == sic_pkg::CHAR_CLOSE && state_ff.open_parens != '0) begin
               nxt.open_parens = state_ff.open_parens - 1'b1;
            end
         end
      end
   end

   // result from the updated state
   always_comb begin
      done = (nxt.open_parens == '0) && (nxt.comment_nesting == '0) &&
             !nxt.inside_string && !nxt.dot_continuation;
      result.complete     = done;
      result.indent_width = '0;
      if (!done) begin
         if (nxt.open_parens != '0) begin
            if (32'(nxt.open_parens) > 32'(sic_pkg::INDENT_MAX / 2)) begin
               result.indent_width = sic_pkg::INDENT_W'(sic_pkg::INDENT_MAX);
            end else begin
               result.indent_width = sic_pkg::INDENT_W'(nxt.open_parens) << 1;
            end
         end else if (nxt.dot_continuation) begin
            result.indent_width = sic_pkg::INDENT_W'(2);
         end
      end
   end

   // state clears after the last byte of a text
   always_comb begin
      if (step && item.last_byte) begin
         state_in = sic_pkg::STATE_RESET;
      end else if (step) begin
         state_in = nxt;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sic_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   `SIC_ASSERT_NEXT(a_clear_after_last, clock, reset, step && item.last_byte, state_ff == sic_pkg::STATE_RESET, "state not cleared after last byte")
   `SIC_ASSERT(a_escape_in_string, clock, reset, !state_ff.escape_pending || state_ff.inside_string, "escape pending outside a string")
   `SIC_ASSERT(a_bar_in_comment, clock, reset, !state_ff.bar_pending || ((state_ff.comment_nesting != '0) && !state_ff.hash_pending), "bar pending outside a block comment")

endmodule

`default_nettype wire

### sv/sexpr_input_completeness_unit.sv
// s-expression input completeness unit: one text byte per cycle
// result path: a last byte passes through the input register and then the result register
// (it waits in the input register while an untaken result occupies the output)
// throughput: one byte per cycle; a last byte stalls only while an untaken result waits
// reset: synchronous active high; clears scanner state and both valid flags
`timescale 1ns / 1ps
`default_nettype none
`include "sexpr_input_completeness_unit_macros.svh"

module sexpr_input_completeness_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [7:0]                    req_text_byte,
   input  wire logic                          req_last_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_complete,
   output logic [sic_pkg::INDENT_W-1:0]       rsp_indent_width
);

   sic_pkg::sic_item_type   req_item;
   sic_pkg::sic_item_type   item;
   sic_pkg::sic_result_type result;
   sic_pkg::sic_result_type rsp_ff;
   logic                    item_valid;
   logic                    step;
   logic                    hold;
   logic                    emit;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   assign req_item.text_byte = req_text_byte;
   assign req_item.last_byte = req_last_byte;

   // a last byte waits while an untaken result occupies the output
   assign hold = item.last_byte && rsp_valid_ff && !rsp_ready;

   sic_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .hold       (hold),
      .item_valid (item_valid),
      .item       (item),
      .step       (step)
   );

   sic_scanner u_scanner (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .result (result)
   );

   // output register
   assign emit = step && item.last_byte;

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_complete     = rsp_ff.complete;
   assign rsp_indent_width = rsp_ff.indent_width;

   // checks
   `SIC_ASSERT(a_rise_from_last, clock, reset, !$rose(rsp_valid_ff) || $past(item_valid && item.last_byte), "result without a last byte")
   `SIC_ASSERT(a_complete_no_indent, clock, reset, !(rsp_valid_ff && rsp_ff.complete) || (rsp_ff.indent_width == '0), "indent on complete text")

endmodule

`default_nettype wire

### dv/testbench.sv
// testbench for the s-expression input completeness unit
// self-checking: a scanner model predicts each result, a monitor compares them
// depends on sic_pkg and sexpr_input_completeness_unit
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLD_OFF_LEN   = 150;
   localparam int DRAIN_CYCLES   = 10;
   localparam int RANDOM_WORDS   = 340;
   localparam int CALM_WORDS     = 140;

   logic                         clock         = 1'b0;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_text_byte = 8'h00;
   logic                         req_last_byte = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_ready     = 1'b0;
   logic                         rsp_complete;
   logic [sic_pkg::INDENT_W-1:0] rsp_indent_width;

   // scanner model state and pending verdicts
   sic_pkg::sic_state_type  scan_state = sic_pkg::STATE_RESET;
   sic_pkg::sic_result_type pending_verdicts[$];
   logic [7:0]              text_buf[$];

   int fail_count       = 0;
   int quiet_cycles     = 0;
   bit sender_gaps      = 1'b1;
   bit receiver_stalls  = 1'b1;
   bit hold_off_request = 1'b0;

   always #5 clock = ~clock;

   sexpr_input_completeness_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_byte    (req_text_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_complete     (rsp_complete),
      .rsp_indent_width (rsp_indent_width)
   );

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // advance the scanner model by one byte, queue a verdict on the last byte
   task automatic scan_word(input logic [7:0] ch, input logic is_last);
      sic_pkg::sic_result_type verdict;
      bit                      mark_taken;
      mark_taken = 1'b0;
      // dot continuation tracks the first non-blank byte of each line
      if (ch == sic_pkg::CHAR_NL) begin
         scan_state.line_blank_so_far = 1'b1;
      end else if (scan_state.line_blank_so_far && ch != sic_pkg::CHAR_SPACE
                   && ch != sic_pkg::CHAR_TAB && ch != sic_pkg::CHAR_CR) begin
         scan_state.line_blank_so_far = 1'b0;
         if (ch != sic_pkg::CHAR_SEMI)
            scan_state.dot_continuation = (ch == sic_pkg::CHAR_DOT);
      end
      if (scan_state.inside_line_comment) begin
         if (ch == sic_pkg::CHAR_NL) scan_state.inside_line_comment = 1'b0;
      end else if (scan_state.comment_nesting != 0) begin
         // inside block comment: look for nested open or close marks
         if (scan_state.hash_pending) begin
            scan_state.hash_pending = 1'b0;
            if (ch == sic_pkg::CHAR_BAR) begin
               if (scan_state.comment_nesting < sic_pkg::DEPTH_MAX)
                  scan_state.comment_nesting = scan_state.comment_nesting + 1'b1;
               mark_taken = 1'b1;
            end
         end else if (scan_state.bar_pending) begin
            scan_state.bar_pending = 1'b0;
            if (ch == sic_pkg::CHAR_HASH) begin
               scan_state.comment_nesting = scan_state.comment_nesting - 1'b1;
               mark_taken = 1'b1;
            end
         end
         if (!mark_taken) begin
            if (ch == sic_pkg::CHAR_HASH) scan_state.hash_pending = 1'b1;
            else if (ch == sic_pkg::CHAR_BAR) scan_state.bar_pending = 1'b1;
         end
      end else if (scan_state.inside_string) begin
         if (scan_state.escape_pending) scan_state.escape_pending = 1'b0;
         else if (ch == sic_pkg::CHAR_BSLASH) scan_state.escape_pending = 1'b1;
         else if (ch == sic_pkg::CHAR_QUOTE) scan_state.inside_string = 1'b0;
      end else begin
         // plain code
         if (scan_state.hash_pending) begin
            scan_state.hash_pending = 1'b0;
            if (ch == sic_pkg::CHAR_BAR) begin
               if (scan_state.comment_nesting < sic_pkg::DEPTH_MAX)
                  scan_state.comment_nesting = scan_state.comment_nesting + 1'b1;
               mark_taken = 1'b1;
            end
         end
         if (!mark_taken) begin
            if (ch == sic_pkg::CHAR_SEMI) begin
               scan_state.inside_line_comment = 1'b1;
            end else if (ch == sic_pkg::CHAR_HASH) begin
               scan_state.hash_pending = 1'b1;
            end else if (ch == sic_pkg::CHAR_QUOTE) begin
               scan_state.inside_string = 1'b1;
            end else if (ch == sic_pkg::CHAR_OPEN) begin
               if (scan_state.open_parens < sic_pkg::DEPTH_MAX)
                  scan_state.open_parens = scan_state.open_parens + 1'b1;
            end else if (ch == sic_pkg::CHAR_CLOSE && scan_state.open_parens != 0) begin
               scan_state.open_parens = scan_state.open_parens - 1'b1;
            end
         end
      end
      if (is_last) begin
         verdict.complete = scan_state.open_parens == 0 && scan_state.comment_nesting == 0
                            && !scan_state.inside_string && !scan_state.dot_continuation;
         if (verdict.complete) verdict.indent_width = '0;
         else if (scan_state.open_parens != 0) begin
            if (scan_state.open_parens * 2 > sic_pkg::INDENT_MAX)
               verdict.indent_width = sic_pkg::INDENT_W'(sic_pkg::INDENT_MAX);
            else verdict.indent_width = sic_pkg::INDENT_W'(scan_state.open_parens * 2);
         end else if (scan_state.dot_continuation) verdict.indent_width = sic_pkg::INDENT_W'(2);
         else verdict.indent_width = '0;
         pending_verdicts.push_back(verdict);
         scan_state = sic_pkg::STATE_RESET;
      end
   endtask

   // offer one word and wait for it to be taken
   task automatic send_word(input logic [7:0] ch, input logic is_last);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= ch;
      req_last_byte <= is_last;
      do @(posedge clock); while (!req_ready);
      scan_word(ch, is_last);
   endtask

   // send the text buffer, marking its final byte
   task automatic send_text();
      foreach (text_buf[i]) send_word(text_buf[i], i == text_buf.size() - 1);
   endtask

   function automatic void load_text(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   // character pickers for generated text
   function automatic logic [7:0] pick_letter();
      return 8'h61 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 5))
         0:       return sic_pkg::CHAR_NL;
         1:       return sic_pkg::CHAR_TAB;
         2:       return sic_pkg::CHAR_CR;
         default: return sic_pkg::CHAR_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] pick_special();
      case ($urandom_range(0, 11))
         0:       return sic_pkg::CHAR_OPEN;
         1:       return sic_pkg::CHAR_CLOSE;
         2:       return sic_pkg::CHAR_QUOTE;
         3:       return sic_pkg::CHAR_BSLASH;
         4:       return sic_pkg::CHAR_SEMI;
         5:       return sic_pkg::CHAR_HASH;
         6:       return sic_pkg::CHAR_BAR;
         7:       return sic_pkg::CHAR_DOT;
         8:       return sic_pkg::CHAR_SPACE;
         9:       return sic_pkg::CHAR_TAB;
         10:      return sic_pkg::CHAR_CR;
         default: return sic_pkg::CHAR_NL;
      endcase
   endfunction

   function automatic logic [7:0] pick_noise();
      case ($urandom_range(0, 3))
         0, 1:    return pick_special();
         2:       return pick_letter();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_atom();
      repeat ($urandom_range(1, 5)) text_buf.push_back(pick_letter());
   endfunction

   // string with random content and escapes
   function automatic void add_string();
      text_buf.push_back(sic_pkg::CHAR_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 4) == 0) begin
            text_buf.push_back(sic_pkg::CHAR_BSLASH);
            text_buf.push_back(8'($urandom_range(0, 255)));
         end else begin
            case ($urandom_range(0, 5))
               0:       text_buf.push_back(sic_pkg::CHAR_OPEN);
               1:       text_buf.push_back(sic_pkg::CHAR_SEMI);
               2:       text_buf.push_back(sic_pkg::CHAR_HASH);
               3:       text_buf.push_back(sic_pkg::CHAR_NL);
               default: text_buf.push_back(pick_letter());
            endcase
         end
      end
      text_buf.push_back(sic_pkg::CHAR_QUOTE);
   endfunction

   // nested block comment
   function automatic void add_block_comment(input int depth);
      text_buf.push_back(sic_pkg::CHAR_HASH);
      text_buf.push_back(sic_pkg::CHAR_BAR);
      repeat ($urandom_range(0, 4)) begin
         if (depth > 0 && $urandom_range(0, 2) == 0) add_block_comment(depth - 1);
         else if ($urandom_range(0, 3) == 0) text_buf.push_back(pick_separator());
         else text_buf.push_back(pick_letter());
      end
      text_buf.push_back(sic_pkg::CHAR_BAR);
      text_buf.push_back(sic_pkg::CHAR_HASH);
   endfunction

   // one well-formed form
   function automatic void add_form(input int depth);
      int kind;
      kind = $urandom_range(0, 6);
      if (depth == 0 || kind == 0) begin
         add_atom();
      end else if (kind == 1) begin
         add_string();
      end else if (kind == 2) begin
         text_buf.push_back(sic_pkg::CHAR_SEMI);
         repeat ($urandom_range(0, 4)) text_buf.push_back(pick_letter());
         text_buf.push_back(sic_pkg::CHAR_NL);
      end else if (kind == 3) begin
         add_block_comment(depth - 1);
      end else begin
         text_buf.push_back(sic_pkg::CHAR_OPEN);
         repeat ($urandom_range(0, 4)) begin
            add_form(depth - 1);
            text_buf.push_back(pick_separator());
         end
         text_buf.push_back(sic_pkg::CHAR_CLOSE);
      end
   endfunction

   // edge cases of each construct, one text at a time
   task automatic test_directed_cases();
      load_text("(");
      send_text();
      // stray close paren
      load_text(")");
      send_text();
      // escaped quote leaves the string open
      text_buf = '{sic_pkg::CHAR_QUOTE, sic_pkg::CHAR_BSLASH, sic_pkg::CHAR_QUOTE};
      send_text();
      load_text(";(");
      send_text();
      load_text("#|(");
      send_text();
      load_text("#|x|#(");
      send_text();
      // hash pending at the last byte
      load_text("#");
      send_text();
      // blank prefix before a dot line
      text_buf = '{sic_pkg::CHAR_SPACE, sic_pkg::CHAR_TAB, sic_pkg::CHAR_CR,
                   sic_pkg::CHAR_DOT};
      send_text();
      // comment line does not clear the dot continuation
      text_buf = '{sic_pkg::CHAR_DOT, sic_pkg::CHAR_NL, sic_pkg::CHAR_SEMI, 8'h63};
      send_text();
      text_buf = '{8'h00, 8'hff};
      send_text();
   endtask

   // paren depth saturates and then counts down from the top
   task automatic test_paren_saturation();
      text_buf.delete();
      repeat (sic_pkg::DEPTH_MAX) text_buf.push_back(sic_pkg::CHAR_OPEN);
      send_text();
      text_buf.delete();
      repeat (sic_pkg::DEPTH_MAX + 5) text_buf.push_back(sic_pkg::CHAR_OPEN);
      text_buf.push_back(sic_pkg::CHAR_CLOSE);
      send_text();
   endtask

   // comment nesting saturates, so one close too few still balances
   task automatic test_comment_saturation();
      text_buf.delete();
      repeat (sic_pkg::DEPTH_MAX + 1) begin
         text_buf.push_back(sic_pkg::CHAR_HASH);
         text_buf.push_back(sic_pkg::CHAR_BAR);
      end
      repeat (sic_pkg::DEPTH_MAX) begin
         text_buf.push_back(sic_pkg::CHAR_BAR);
         text_buf.push_back(sic_pkg::CHAR_HASH);
      end
      send_text();
   endtask

   // receiver holds off while short texts keep coming
   task automatic test_result_backpressure();
      sender_gaps      = 1'b0;
      hold_off_request = 1'b1;
      repeat (40) begin
         text_buf = '{pick_special()};
         send_text();
      end
      sender_gaps = 1'b1;
   endtask

   // mostly well-formed texts, some cut short, some noise
   task automatic test_random_text(input int word_budget);
      int sent;
      int kind;
      int keep;
      sent = 0;
      while (sent < word_budget) begin
         text_buf.delete();
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            repeat ($urandom_range(1, 3)) begin
               add_form($urandom_range(0, 3));
               if ($urandom_range(0, 1) == 0) text_buf.push_back(pick_separator());
            end
            if ($urandom_range(0, 4) == 0) begin
               text_buf.push_back(sic_pkg::CHAR_NL);
               text_buf.push_back(sic_pkg::CHAR_DOT);
               add_atom();
            end
         end else if (kind < 8) begin
            add_form(3);
            keep = $urandom_range(1, text_buf.size());
            while (text_buf.size() > keep) void'(text_buf.pop_back());
         end else begin
            repeat ($urandom_range(1, 30)) text_buf.push_back(pick_noise());
         end
         send_text();
         sent += text_buf.size();
      end
   endtask

   // result side: random stalls, one long hold-off on request
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each result word with the oldest pending verdict
   always @(posedge clock) begin : result_check
      sic_pkg::sic_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected result complete=%0d indent=%0d",
                                      rsp_complete, rsp_indent_width));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_complete !== want.complete)
               report_mismatch($sformatf("complete got %0d expected %0d",
                                         rsp_complete, want.complete));
            if (rsp_indent_width !== want.indent_width)
               report_mismatch($sformatf("indent_width got %0d expected %0d",
                                         rsp_indent_width, want.indent_width));
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_paren_saturation();
      test_comment_saturation();
      test_result_backpressure();
      test_random_text(RANDOM_WORDS - CALM_WORDS);
      // last stretch at full rate on both sides
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      test_random_text(CALM_WORDS);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
